@@ hdl/las_pkg.sv @@
package las_pkg;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_ERROR = 3'd4;

  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_REACHED = 2'd1;
  localparam logic [1:0] POS_NOT     = 2'd2;

  localparam logic [1:0] CMD_STOP   = 2'd0;
  localparam logic [1:0] CMD_LOCK   = 2'd1;
  localparam logic [1:0] CMD_UNLOCK = 2'd2;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_CONFLICT = 2'd1;
  localparam logic [1:0] FAULT_TIMEOUT  = 2'd2;

  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd0;
  localparam logic [1:0] CFG_ASSERT_COUNT  = 2'd1;
  localparam logic [1:0] CFG_RELEASE_COUNT = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd2500;
  localparam logic [2:0]  ASSERT_RESET  = 3'd5;
  localparam logic [2:0]  RELEASE_RESET = 3'd2;

  localparam int ITEM_WIDTH   = 5;
  localparam int RESULT_WIDTH = 12;

  typedef struct packed {
    logic       port_chosen;
    logic [1:0] cmd_event;
    logic       unlock_pos_pin;
    logic       lock_pos_pin;
  } item_t;

  typedef struct packed {
    logic [1:0] unlocked_status;
    logic [1:0] locked_status;
    logic       move_dir;
    logic       motor_start;
    logic       motor_on;
    logic [1:0] error_code;
    logic [2:0] ctrl_state;
  } result_t;

endpackage

@@ hdl/las_qualifier.sv @@
module las_qualifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       pin,
  input  logic [2:0] assert_count,
  input  logic [2:0] release_count,
  output logic [1:0] level_next
);

  logic [2:0] acnt;
  logic [2:0] rcnt;
  logic [1:0] level;
  logic [2:0] acnt_next;
  logic [2:0] rcnt_next;

  always_comb begin
    acnt_next  = acnt;
    rcnt_next  = rcnt;
    level_next = level;
    if (pin) begin
      rcnt_next = 3'd0;
      acnt_next = acnt + 3'd1;
      if (acnt_next >= assert_count) begin
        level_next = las_pkg::POS_REACHED;
        acnt_next  = 3'd0;
      end
    end else begin
      acnt_next = 3'd0;
      rcnt_next = rcnt + 3'd1;
      if (rcnt_next >= release_count) begin
        level_next = las_pkg::POS_NOT;
        rcnt_next  = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acnt  <= 3'd0;
      rcnt  <= 3'd0;
      level <= las_pkg::POS_UNKNOWN;
    end else if (advance) begin
      acnt  <= acnt_next;
      rcnt  <= rcnt_next;
      level <= level_next;
    end
  end

endmodule

@@ hdl/las_sequencer.sv @@
module las_sequencer #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [1:0]          lock_level,
  input  logic [1:0]          unlock_level,
  input  logic [1:0]          cmd_event,
  input  logic                port_chosen,
  input  logic [15:0]         timeout_ticks,
  output las_pkg::result_t    result
);

  localparam int CMP_WIDTH = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [1:0]             locked_flag;
  logic [1:0]             unlocked_flag;
  logic                   position_checked;
  logic [2:0]             seq_state;
  logic [1:0]             active_cmd;
  logic [1:0]             previous_cmd;
  logic [TIMER_WIDTH-1:0] stroke_timer;
  logic                   timer_running;
  logic                   motor_enabled;
  logic [1:0]             fault_code;

  logic [1:0]             locked_flag_next;
  logic [1:0]             unlocked_flag_next;
  logic                   position_checked_next;
  logic [2:0]             seq_state_next;
  logic [1:0]             active_cmd_next;
  logic [1:0]             previous_cmd_next;
  logic [TIMER_WIDTH-1:0] stroke_timer_next;
  logic                   timer_running_next;
  logic                   motor_enabled_next;
  logic [1:0]             fault_code_next;
  logic                   start;
  logic                   dir;
  logic                   timed_out;

  assign timed_out = CMP_WIDTH'(stroke_timer) >= CMP_WIDTH'(timeout_ticks);

  always_comb begin
    locked_flag_next      = locked_flag;
    unlocked_flag_next    = unlocked_flag;
    position_checked_next = position_checked;
    seq_state_next        = seq_state;
    active_cmd_next       = active_cmd;
    previous_cmd_next     = previous_cmd;
    stroke_timer_next     = stroke_timer;
    timer_running_next    = timer_running;
    motor_enabled_next    = motor_enabled;
    fault_code_next       = fault_code;
    start                 = 1'b0;
    dir                   = 1'b0;

    if (lock_level == las_pkg::POS_REACHED && unlock_level == las_pkg::POS_NOT) begin
      locked_flag_next      = las_pkg::POS_REACHED;
      position_checked_next = 1'b1;
    end
    if (lock_level == las_pkg::POS_NOT && unlock_level == las_pkg::POS_REACHED) begin
      unlocked_flag_next    = las_pkg::POS_REACHED;
      position_checked_next = 1'b1;
    end
    if (lock_level == las_pkg::POS_REACHED && unlock_level == las_pkg::POS_REACHED) begin
      seq_state_next        = las_pkg::ST_ERROR;
      fault_code_next       = las_pkg::FAULT_CONFLICT;
      position_checked_next = 1'b1;
    end
    if (lock_level == las_pkg::POS_NOT && unlock_level == las_pkg::POS_NOT) begin
      locked_flag_next      = las_pkg::POS_NOT;
      unlocked_flag_next    = las_pkg::POS_NOT;
      position_checked_next = 1'b1;
    end

    if (cmd_event == las_pkg::CMD_LOCK || cmd_event == las_pkg::CMD_UNLOCK) begin
      active_cmd_next = cmd_event;
    end

    case (seq_state_next)
      las_pkg::ST_INIT: begin
        if (port_chosen && position_checked_next) begin
          seq_state_next = las_pkg::ST_READY;
        end
      end
      las_pkg::ST_READY: begin
        if (previous_cmd_next != active_cmd_next && active_cmd_next != las_pkg::CMD_STOP) begin
          seq_state_next    = las_pkg::ST_RUN;
          previous_cmd_next = active_cmd_next;
        end
      end
      las_pkg::ST_RUN: begin
        if (active_cmd_next == las_pkg::CMD_LOCK && locked_flag_next != las_pkg::POS_REACHED) begin
          start              = 1'b1;
          dir                = 1'b0;
          timer_running_next = 1'b1;
          stroke_timer_next  = '0;
        end else if (active_cmd_next == las_pkg::CMD_UNLOCK &&
                     unlocked_flag_next != las_pkg::POS_REACHED) begin
          start              = 1'b1;
          dir                = 1'b1;
          timer_running_next = 1'b1;
          stroke_timer_next  = '0;
        end
        motor_enabled_next = 1'b1;
        seq_state_next     = las_pkg::ST_CHECK;
      end
      las_pkg::ST_CHECK: begin
        // A completed lock stroke clears the command, so the unlock check is then skipped.
        if (active_cmd_next == las_pkg::CMD_LOCK) begin
          if (locked_flag_next == las_pkg::POS_NOT && timed_out) begin
            seq_state_next  = las_pkg::ST_ERROR;
            fault_code_next = las_pkg::FAULT_TIMEOUT;
          end else if (locked_flag_next == las_pkg::POS_REACHED && !timed_out) begin
            motor_enabled_next = 1'b0;
            timer_running_next = 1'b0;
            stroke_timer_next  = '0;
            active_cmd_next    = las_pkg::CMD_STOP;
            previous_cmd_next  = las_pkg::CMD_STOP;
            seq_state_next     = las_pkg::ST_READY;
          end
        end
        if (active_cmd_next == las_pkg::CMD_UNLOCK) begin
          if (unlocked_flag_next == las_pkg::POS_NOT && timed_out) begin
            seq_state_next  = las_pkg::ST_ERROR;
            fault_code_next = las_pkg::FAULT_TIMEOUT;
          end else if (unlocked_flag_next == las_pkg::POS_REACHED && !timed_out) begin
            motor_enabled_next = 1'b0;
            timer_running_next = 1'b0;
            stroke_timer_next  = '0;
            active_cmd_next    = las_pkg::CMD_STOP;
            previous_cmd_next  = las_pkg::CMD_STOP;
            seq_state_next     = las_pkg::ST_READY;
          end
        end
      end
      default: begin
        motor_enabled_next = 1'b0;
        timer_running_next = 1'b0;
        stroke_timer_next  = '0;
      end
    endcase

    if (timer_running_next && stroke_timer_next != TIMER_MAX) begin
      stroke_timer_next = stroke_timer_next + 1'b1;
    end
  end

  always_comb begin
    result.ctrl_state      = seq_state_next;
    result.error_code      = fault_code_next;
    result.motor_on        = motor_enabled_next;
    result.motor_start     = start;
    result.move_dir        = dir;
    result.locked_status   = locked_flag_next;
    result.unlocked_status = unlocked_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked_flag      <= las_pkg::POS_UNKNOWN;
      unlocked_flag    <= las_pkg::POS_UNKNOWN;
      position_checked <= 1'b0;
      seq_state        <= las_pkg::ST_INIT;
      active_cmd       <= las_pkg::CMD_STOP;
      previous_cmd     <= las_pkg::CMD_STOP;
      stroke_timer     <= '0;
      timer_running    <= 1'b0;
      motor_enabled    <= 1'b0;
      fault_code       <= las_pkg::FAULT_NONE;
    end else if (advance) begin
      locked_flag      <= locked_flag_next;
      unlocked_flag    <= unlocked_flag_next;
      position_checked <= position_checked_next;
      seq_state        <= seq_state_next;
      active_cmd       <= active_cmd_next;
      previous_cmd     <= previous_cmd_next;
      stroke_timer     <= stroke_timer_next;
      timer_running    <= timer_running_next;
      motor_enabled    <= motor_enabled_next;
      fault_code       <= fault_code_next;
    end
  end

endmodule

@@ hdl/lock_actuator_sequencer_unit.sv @@
// Lock actuator sequencer. Each transfer on the input stream is one sensor sample tick
// carrying the raw end-position sensor levels, a qualified lock or unlock command and
// the port-chosen flag; each tick produces exactly one result transfer with the
// sequencer state, error code, motor controls and the two position statuses. A tick
// passes through an input register and one step of combinational logic into the
// result register, so the block takes one tick per clock cycle unless the output
// stalls; the result register stalls the input side only when a result waits and
// the next tick is also waiting. Configuration writes are taken in any cycle and
// must only be issued while no tick is in flight. Errors are sticky until reset.
module lock_actuator_sequencer_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // lock_pos_pin[0], unlock_pos_pin[1], cmd_event[3:2], port_chosen[4], zero[7:5]
  input  logic [7:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ctrl_state[2:0], error_code[4:3], motor_on[5], motor_start[6], move_dir[7],
  // locked_status[9:8], unlocked_status[11:10], zero[15:12]
  output logic [15:0] m_tdata,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]       timeout_ticks;
  logic [2:0]        assert_count;
  logic [2:0]        release_count;
  logic              item_valid;
  las_pkg::item_t    item;
  logic              advance;
  logic [1:0]        lock_level;
  logic [1:0]        unlock_level;
  las_pkg::result_t  result;
  las_pkg::result_t  result_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= las_pkg::TIMEOUT_RESET;
      assert_count  <= las_pkg::ASSERT_RESET;
      release_count <= las_pkg::RELEASE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        las_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        las_pkg::CFG_ASSERT_COUNT:  assert_count  <= cfg_data[2:0];
        las_pkg::CFG_RELEASE_COUNT: release_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= s_tdata[las_pkg::ITEM_WIDTH-1:0];
    end
  end

  las_qualifier u_lock_qual (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .pin           (item.lock_pos_pin),
    .assert_count  (assert_count),
    .release_count (release_count),
    .level_next    (lock_level)
  );

  las_qualifier u_unlock_qual (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .pin           (item.unlock_pos_pin),
    .assert_count  (assert_count),
    .release_count (release_count),
    .level_next    (unlock_level)
  );

  las_sequencer #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_sequencer (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .lock_level    (lock_level),
    .unlock_level  (unlock_level),
    .cmd_event     (item.cmd_event),
    .port_chosen   (item.port_chosen),
    .timeout_ticks (timeout_ticks),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign m_tdata = {(16 - las_pkg::RESULT_WIDTH)'(0), result_reg};

endmodule

@@ tb/tb.sv @@
module tb;

  localparam int TW = 16;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int PHASE_LEN = 250;
  localparam int CALM_TAIL = 80;
  localparam int HOLD_PHASE = 7;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 3000;
  localparam las_pkg::result_t AT_RESET = '{ctrl_state: las_pkg::ST_INIT,
                                            error_code: las_pkg::FAULT_NONE,
                                            default: '0};

  typedef struct packed {
    las_pkg::item_t   it;
    logic             lit;
    las_pkg::result_t exp;
  } drow_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  lock_actuator_sequencer_unit #(.TIMER_WIDTH(TW)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the configuration and the sequencer state.
  logic [TW-1:0] cfg_timeout;
  logic [2:0]    cfg_assert;
  logic [2:0]    cfg_release;
  logic [2:0]    lk_acnt, lk_rcnt, ul_acnt, ul_rcnt;
  logic [1:0]    lk_level, ul_level, lk_flag, ul_flag;
  logic          pos_checked;
  logic [2:0]    seq;
  logic [1:0]    act_cmd, prev_cmd;
  logic [TW-1:0] stroke_t;
  logic          t_run;
  logic          motor_en;
  logic [1:0]    fault;

  las_pkg::result_t expected_status[$];
  drow_t            dir_tab [0:24];

  // Actuator stand-in that drives the sensor pins.
  logic plant_unlock;
  int   travel_left;
  int   settled_ticks;
  int   stroke_age;
  logic reversed;
  logic moves_allowed;
  logic noise_on;
  logic prev_spur;

  int   src_idle_pct;
  int   snk_idle_pct;
  logic hold_req;
  logic hold_done;
  int   hold_left;
  int   stall_left;
  int   quiet_cycles;
  int   n_bad;
  int   n_sent;
  int   n_results;
  int   n_starts;
  int   n_settings;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic las_pkg::item_t mk_item(logic l, logic u, logic [1:0] c, logic p);
    las_pkg::item_t it;
    it.lock_pos_pin = l;
    it.unlock_pos_pin = u;
    it.cmd_event = c;
    it.port_chosen = p;
    return it;
  endfunction

  function automatic drow_t drow(logic l, logic u, logic [1:0] c, logic p, logic lit,
                                 las_pkg::result_t exp);
    drow_t d;
    d.it = mk_item(l, u, c, p);
    d.lit = lit;
    d.exp = exp;
    return d;
  endfunction

  task automatic qualify(input logic pin, inout logic [2:0] ac, inout logic [2:0] rc,
                         inout logic [1:0] lvl);
    if (pin) begin
      rc = '0;
      ac = ac + 3'd1;
      if (ac >= cfg_assert) begin
        lvl = las_pkg::POS_REACHED;
        ac = '0;
      end
    end else begin
      ac = '0;
      rc = rc + 3'd1;
      if (rc >= cfg_release) begin
        lvl = las_pkg::POS_NOT;
        rc = '0;
      end
    end
  endtask

  task automatic halt_motor();
    motor_en = 1'b0;
    t_run = 1'b0;
    stroke_t = '0;
  endtask

  task automatic check_stroke(input logic [1:0] c, input logic [1:0] flag);
    if (act_cmd == c) begin
      if (flag == las_pkg::POS_NOT && stroke_t >= cfg_timeout) begin
        seq = las_pkg::ST_ERROR;
        fault = las_pkg::FAULT_TIMEOUT;
      end else if (flag == las_pkg::POS_REACHED && stroke_t < cfg_timeout) begin
        halt_motor();
        act_cmd = las_pkg::CMD_STOP;
        prev_cmd = las_pkg::CMD_STOP;
        seq = las_pkg::ST_READY;
      end
    end
  endtask

  task automatic sequencer_step(input las_pkg::item_t it, output las_pkg::result_t r);
    logic st;
    logic dr;
    st = 1'b0;
    dr = 1'b0;
    qualify(it.lock_pos_pin, lk_acnt, lk_rcnt, lk_level);
    qualify(it.unlock_pos_pin, ul_acnt, ul_rcnt, ul_level);
    if (lk_level == las_pkg::POS_REACHED && ul_level == las_pkg::POS_NOT) begin
      lk_flag = las_pkg::POS_REACHED;
      pos_checked = 1'b1;
    end
    if (lk_level == las_pkg::POS_NOT && ul_level == las_pkg::POS_REACHED) begin
      ul_flag = las_pkg::POS_REACHED;
      pos_checked = 1'b1;
    end
    if (lk_level == las_pkg::POS_REACHED && ul_level == las_pkg::POS_REACHED) begin
      seq = las_pkg::ST_ERROR;
      fault = las_pkg::FAULT_CONFLICT;
      pos_checked = 1'b1;
    end
    if (lk_level == las_pkg::POS_NOT && ul_level == las_pkg::POS_NOT) begin
      lk_flag = las_pkg::POS_NOT;
      ul_flag = las_pkg::POS_NOT;
      pos_checked = 1'b1;
    end
    if (it.cmd_event == las_pkg::CMD_LOCK || it.cmd_event == las_pkg::CMD_UNLOCK)
      act_cmd = it.cmd_event;
    case (seq)
      las_pkg::ST_INIT: begin
        if (it.port_chosen && pos_checked) seq = las_pkg::ST_READY;
      end
      las_pkg::ST_READY: begin
        if (prev_cmd != act_cmd && act_cmd != las_pkg::CMD_STOP) begin
          seq = las_pkg::ST_RUN;
          prev_cmd = act_cmd;
        end
      end
      las_pkg::ST_RUN: begin
        if (act_cmd == las_pkg::CMD_LOCK && lk_flag != las_pkg::POS_REACHED) begin
          st = 1'b1;
          dr = 1'b0;
          t_run = 1'b1;
          stroke_t = '0;
        end else if (act_cmd == las_pkg::CMD_UNLOCK && ul_flag != las_pkg::POS_REACHED) begin
          st = 1'b1;
          dr = 1'b1;
          t_run = 1'b1;
          stroke_t = '0;
        end
        motor_en = 1'b1;
        seq = las_pkg::ST_CHECK;
      end
      las_pkg::ST_CHECK: begin
        check_stroke(las_pkg::CMD_LOCK, lk_flag);
        check_stroke(las_pkg::CMD_UNLOCK, ul_flag);
      end
      default: begin
        halt_motor();
      end
    endcase
    if (t_run && stroke_t != {TW{1'b1}}) stroke_t = stroke_t + 1'b1;
    if (st) n_starts++;
    r.ctrl_state = seq;
    r.error_code = fault;
    r.motor_on = motor_en;
    r.motor_start = st;
    r.move_dir = dr;
    r.locked_status = lk_flag;
    r.unlocked_status = ul_flag;
  endtask

  task automatic send_tick(input las_pkg::item_t it, input logic lit,
                           input las_pkg::result_t lit_exp);
    int gap;
    las_pkg::result_t pred;
    gap = 0;
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sequencer_step(it, pred);
    expected_status.push_back(lit ? lit_exp : pred);
    n_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] t, input logic [2:0] a, input logic [2:0] r);
    cfg_write <= 1'b1;
    cfg_index <= las_pkg::CFG_TIMEOUT_TICKS;
    cfg_data <= t;
    @(posedge clk);
    cfg_timeout = t;
    cfg_index <= las_pkg::CFG_ASSERT_COUNT;
    cfg_data <= {13'd0, a};
    @(posedge clk);
    cfg_assert = a;
    cfg_index <= las_pkg::CFG_RELEASE_COUNT;
    cfg_data <= {13'd0, r};
    @(posedge clk);
    cfg_release = r;
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic next_plant_tick(input logic calm, output las_pkg::item_t it);
    logic [1:0] c;
    logic lk;
    logic ul;
    logic spur;
    int r;
    c = las_pkg::CMD_STOP;
    spur = 1'b0;
    if (!calm) begin
      r = $urandom_range(0, 999);
      if (travel_left == 0 && settled_ticks >= 10 && r < 60) begin
        if (moves_allowed && r < 36) begin
          plant_unlock = ~plant_unlock;
          travel_left = $urandom_range(2, 60);
          stroke_age = 0;
          reversed = 1'b0;
        end
        c = plant_unlock ? las_pkg::CMD_UNLOCK : las_pkg::CMD_LOCK;
        settled_ticks = 0;
      end else if (travel_left > 0 && moves_allowed && !reversed && stroke_age < 100 &&
                   r >= 980) begin
        plant_unlock = ~plant_unlock;
        travel_left = $urandom_range(2, 60);
        reversed = 1'b1;
        c = plant_unlock ? las_pkg::CMD_UNLOCK : las_pkg::CMD_LOCK;
      end else if (r >= 960 && r < 980) begin
        c = CMD_IGNORED;
      end else if (travel_left > 0 && r >= 940 && r < 960) begin
        c = plant_unlock ? las_pkg::CMD_UNLOCK : las_pkg::CMD_LOCK;
      end
    end
    if (travel_left > 0) begin
      travel_left--;
      stroke_age++;
      lk = 1'b0;
      ul = 1'b0;
    end else begin
      lk = !plant_unlock;
      ul = plant_unlock;
      settled_ticks++;
    end
    if (noise_on && !calm) begin
      if ($urandom_range(0, 99) < 3) begin
        lk = 1'b0;
        ul = 1'b0;
      end
      // A lone spurious high never reaches a threshold of two or more.
      if (cfg_assert >= 3'd2 && !prev_spur && $urandom_range(0, 99) < 2) begin
        spur = 1'b1;
        if (lk) ul = 1'b1;
        else if (ul) lk = 1'b1;
        else if ($urandom_range(0, 1) == 0) lk = 1'b1;
        else ul = 1'b1;
      end
    end
    prev_spur = spur;
    it = mk_item(lk, ul, c, $urandom_range(0, 19) != 0);
  endtask

  task automatic check_status(input las_pkg::result_t got);
    las_pkg::result_t want;
    n_results++;
    if (expected_status.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("result transfer %0d arrived with nothing pending: %h",
                                n_results, got);
    end else begin
      want = expected_status.pop_front();
      if (got.ctrl_state !== want.ctrl_state || got.error_code !== want.error_code ||
          got.motor_on !== want.motor_on || got.motor_start !== want.motor_start ||
          got.move_dir !== want.move_dir || got.locked_status !== want.locked_status ||
          got.unlocked_status !== want.unlocked_status) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("result %0d expected st %0d err %0d on %b start %b dir %b lk %0d ul %0d",
                   n_results, want.ctrl_state, want.error_code, want.motor_on,
                   want.motor_start, want.move_dir, want.locked_status, want.unlocked_status);
          $display("result %0d actual   st %0d err %0d on %b start %b dir %b lk %0d ul %0d",
                   n_results, got.ctrl_state, got.error_code, got.motor_on,
                   got.motor_start, got.move_dir, got.locked_status, got.unlocked_status);
        end
      end
    end
  endtask

  initial begin
    m_tready <= 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_status(las_pkg::result_t'(m_tdata[11:0]));
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        stall_left = $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    las_pkg::item_t it;
    int ph;
    int k;
    logic lk;
    logic ul;
    logic [1:0] c;
    logic [15:0] t_set;
    logic [2:0] a_set;
    logic [2:0] r_set;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_write <= 1'b0;
    cfg_index <= las_pkg::CFG_TIMEOUT_TICKS;
    cfg_data <= '0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    n_bad = 0;
    n_sent = 0;
    n_results = 0;
    n_starts = 0;
    n_settings = 1;
    src_idle_pct = 15;
    snk_idle_pct = 15;

    cfg_timeout = las_pkg::TIMEOUT_RESET;
    cfg_assert = las_pkg::ASSERT_RESET;
    cfg_release = las_pkg::RELEASE_RESET;
    lk_acnt = '0;
    lk_rcnt = '0;
    ul_acnt = '0;
    ul_rcnt = '0;
    lk_level = las_pkg::POS_UNKNOWN;
    ul_level = las_pkg::POS_UNKNOWN;
    lk_flag = las_pkg::POS_UNKNOWN;
    ul_flag = las_pkg::POS_UNKNOWN;
    pos_checked = 1'b0;
    seq = las_pkg::ST_INIT;
    act_cmd = las_pkg::CMD_STOP;
    prev_cmd = las_pkg::CMD_STOP;
    stroke_t = '0;
    t_run = 1'b0;
    motor_en = 1'b0;
    fault = las_pkg::FAULT_NONE;

    // Bring-up from the locked end, an unlock stuck on an unknown status, a lock that
    // is already in place, then a full stroke to the unlocked end.
    dir_tab[0]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b0, 1'b1, AT_RESET);
    dir_tab[1]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b0, 1'b1, AT_RESET);
    dir_tab[2]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b0, 1'b0, '0);
    dir_tab[3]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b0, 1'b0, '0);
    dir_tab[4]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b0, 1'b0, '0);
    dir_tab[5]  = drow(1'b1, 1'b0, CMD_IGNORED,         1'b1, 1'b0, '0);
    dir_tab[6]  = drow(1'b1, 1'b0, las_pkg::CMD_UNLOCK, 1'b1, 1'b0, '0);
    dir_tab[7]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[8]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[9]  = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b0, 1'b0, '0);
    dir_tab[10] = drow(1'b1, 1'b0, las_pkg::CMD_LOCK,   1'b1, 1'b0, '0);
    dir_tab[11] = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[12] = drow(1'b1, 1'b0, las_pkg::CMD_LOCK,   1'b1, 1'b0, '0);
    dir_tab[13] = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[14] = drow(1'b1, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[15] = drow(1'b0, 1'b0, las_pkg::CMD_UNLOCK, 1'b1, 1'b0, '0);
    dir_tab[16] = drow(1'b0, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[17] = drow(1'b0, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[18] = drow(1'b0, 1'b1, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[19] = drow(1'b0, 1'b1, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[20] = drow(1'b0, 1'b1, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[21] = drow(1'b0, 1'b1, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[22] = drow(1'b0, 1'b1, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[23] = drow(1'b0, 1'b0, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);
    dir_tab[24] = drow(1'b0, 1'b1, las_pkg::CMD_STOP,   1'b1, 1'b0, '0);

    plant_unlock = 1'b1;
    travel_left = 0;
    settled_ticks = 10;
    stroke_age = 0;
    reversed = 1'b0;
    prev_spur = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < 25; k++) send_tick(dir_tab[k].it, dir_tab[k].lit, dir_tab[k].exp);

    for (ph = 0; ph <= HOLD_PHASE; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: begin t_set = 16'hFFFF; a_set = 3'd7; r_set = 3'd7; end
          2: begin t_set = 16'd400;  a_set = 3'd0; r_set = 3'd0; end
          3: begin t_set = 16'd1000; a_set = 3'd1; r_set = 3'd7; end
          4: begin t_set = 16'd600;  a_set = 3'd7; r_set = 3'd0; end
          HOLD_PHASE: begin
            t_set = 16'd1;
            a_set = 3'($urandom_range(0, 7));
            r_set = 3'($urandom_range(0, 7));
          end
          default: begin
            t_set = 16'($urandom_range(400, 65535));
            a_set = 3'($urandom_range(0, 7));
            r_set = 3'($urandom_range(0, 7));
          end
        endcase
        wait_idle();
        write_regs(t_set, a_set, r_set);
      end
      // With a one-tick timeout only strokes that are already in position can finish.
      moves_allowed = (ph != HOLD_PHASE);
      noise_on = (ph != HOLD_PHASE);
      case ($urandom_range(0, 2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 6;
        default: src_idle_pct = 20;
      endcase
      case ($urandom_range(0, 2))
        0: snk_idle_pct = 0;
        1: snk_idle_pct = 6;
        default: snk_idle_pct = 20;
      endcase
      for (k = 0; k < PHASE_LEN; k++) begin
        if (ph == 1 && k == 40) hold_req = 1'b1;
        next_plant_tick(k >= PHASE_LEN - CALM_TAIL, it);
        send_tick(it, 1'b0, '0);
      end
    end

    // Zero timeout: a stroke in position never finishes, a stroke out of position
    // times out at once, and a later sensor conflict overrides the error code.
    wait_idle();
    write_regs(16'd0, 3'd3, 3'd3);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (k = 0; k < 60; k++) begin
      lk = !plant_unlock;
      ul = plant_unlock;
      c = las_pkg::CMD_STOP;
      if (k == 10) c = plant_unlock ? las_pkg::CMD_UNLOCK : las_pkg::CMD_LOCK;
      if (k == 25) c = plant_unlock ? las_pkg::CMD_LOCK : las_pkg::CMD_UNLOCK;
      if (k >= 40 && k < 52) begin
        lk = 1'b1;
        ul = 1'b1;
      end
      send_tick(mk_item(lk, ul, c, 1'b1), 1'b0, '0);
    end
    for (k = 0; k < 100; k++) begin
      it = mk_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      send_tick(it, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Covered %0d sample ticks and %0d results over %0d register settings.",
             n_sent, n_results, n_settings);
    $display("Predicted %0d motor starts; ended with error code %0d; %0d mismatches.",
             n_starts, fault, n_bad);
    if (n_bad == 0 && expected_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
